@@ src/cbq_pkg.sv @@
package cbq_pkg;

  // field and datapath widths
  localparam int SMP_W  = 24;
  localparam int COEF_W = 32;
  localparam int SIG_W  = 40;
  localparam int CH_W   = 2;
  localparam int SEC_W  = 3;
  localparam int SEL_W  = 2;

  // operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // coefficient select codes
  localparam logic [SEL_W-1:0] COEF_A1 = 2'd0;
  localparam logic [SEL_W-1:0] COEF_A2 = 2'd1;
  localparam logic [SEL_W-1:0] COEF_B1 = 2'd2;
  localparam logic [SEL_W-1:0] COEF_B2 = 2'd3;

  // unity gain in q8.24
  localparam logic signed [COEF_W-1:0] GAIN_UNITY = 32'sh0100_0000;

  // saturation limits of the internal q17.23 signal
  localparam logic signed [45:0] SIG_MAX_W = 46'sh00_7F_FFFF_FFFF;
  localparam logic signed [45:0] SIG_MIN_W = -46'sh00_80_0000_0000;

  typedef struct packed {
    logic                     op;
    logic [CH_W-1:0]          channel;
    logic signed [SMP_W-1:0]  sample;
    logic [SEC_W-1:0]         section;
    logic [SEL_W-1:0]         coef_sel;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel_out;
    logic signed [SMP_W-1:0] sample_out;
  } out_item_t;

  // start of a sample: every cell fetches the channel's delay pair
  typedef struct packed {
    logic            go;
    logic [CH_W-1:0] channel;
  } start_t;

  // coefficient write broadcast to all cells
  typedef struct packed {
    logic                     en;
    logic [SEC_W-1:0]         section;
    logic [SEL_W-1:0]         sel;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  // signal word passed from one section to the next
  typedef struct packed {
    logic                    vld;
    logic signed [SIG_W-1:0] smp;
  } link_t;

  // clamp a widened sum back to the 40-bit signal range
  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [45:0] v);
    logic signed [SIG_W-1:0] r;
    if (v > SIG_MAX_W) begin
      r = SIG_MAX_W[SIG_W-1:0];
    end else if (v < SIG_MIN_W) begin
      r = SIG_MIN_W[SIG_W-1:0];
    end else begin
      r = v[SIG_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/cbq_cell.sv @@
module cbq_cell #(
  parameter int CHAN_COUNT = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cbq_pkg::start_t   start,
  input  cbq_pkg::coef_wr_t coef_wr,
  input  cbq_pkg::link_t    x_in,
  output cbq_pkg::link_t    y_out,
  output logic              busy
);

  localparam int CH_AW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
  localparam int SW    = cbq_pkg::SIG_W;
  localparam int CW    = cbq_pkg::COEF_W;
  localparam logic signed [71:0] RND_Q28 = 72'sd1 <<< 27;

  // section coefficients
  logic signed [CW-1:0] coef_r [4];

  // per-channel delay pair {v1, v2}
  logic [2*SW-1:0]       dly_mem [CHAN_COUNT];
  logic [CHAN_COUNT-1:0] dly_vld_r;
  logic [2*SW-1:0]       rd_r;
  logic                  rd_vld_r;
  logic [CH_AW-1:0]      ch_idx_r;
  logic [CH_AW-1:0]      start_idx;

  logic signed [SW-1:0]  v1;
  logic signed [SW-1:0]  v2;
  logic signed [SW-1:0]  y_new;

  // stage registers
  logic                  s0_vld_r;
  logic signed [SW-1:0]  x_s0_r;
  logic signed [SW-1:0]  y_s0_r;
  logic                  s1_vld_r;
  logic signed [52:0]    lo_r [4];
  logic signed [51:0]    hi_r [4];
  logic                  s2_vld_r;
  logic signed [43:0]    prod_r [4];

  logic signed [CW-1:0]  mc [4];
  logic signed [SW-1:0]  ms [4];
  logic signed [71:0]    full [4];
  logic signed [SW-1:0]  v1_new;
  logic signed [SW-1:0]  v2_new;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        coef_r[i] <= '0;
      end
    end else if (coef_wr.en && (int'(coef_wr.section) == CELL_IDX)) begin
      coef_r[coef_wr.sel] <= coef_wr.value;
    end
  end

  assign start_idx = CH_AW'(start.channel);

  // delay memory, written after the update, read once per sample
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      dly_mem[ch_idx_r] <= {v1_new, v2_new};
    end
    if (start.go) begin
      rd_r <= dly_mem[start_idx];
    end
  end

  // entry valid bits stand in for the all-zero reset of the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (s2_vld_r) begin
        dly_vld_r[ch_idx_r] <= 1'b1;
      end
      if (start.go) begin
        rd_vld_r <= dly_vld_r[start_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.go) begin
      ch_idx_r <= start_idx;
    end
  end

  assign v1 = rd_vld_r ? $signed(rd_r[2*SW-1:SW]) : '0;
  assign v2 = rd_vld_r ? $signed(rd_r[SW-1:0])    : '0;

  // section output, registered and handed on to the next cell
  assign y_new = cbq_pkg::sat_sig(46'(v1) + 46'(x_in.smp));

  always_ff @(posedge clk) begin
    if (x_in.vld) begin
      x_s0_r <= x_in.smp;
      y_s0_r <= y_new;
    end
  end

  assign y_out.vld = s0_vld_r;
  assign y_out.smp = y_s0_r;

  // product operands: b1*x, a1*y, b2*x, a2*y
  always_comb begin
    mc[0] = coef_r[cbq_pkg::COEF_B1];
    mc[1] = coef_r[cbq_pkg::COEF_A1];
    mc[2] = coef_r[cbq_pkg::COEF_B2];
    mc[3] = coef_r[cbq_pkg::COEF_A2];
    ms[0] = x_s0_r;
    ms[1] = y_s0_r;
    ms[2] = x_s0_r;
    ms[3] = y_s0_r;
  end

  // partial products on the low and high 20-bit halves of the operand
  always_ff @(posedge clk) begin
    if (s0_vld_r) begin
      for (int i = 0; i < 4; i++) begin
        lo_r[i] <= 53'(mc[i]) * 53'($signed({1'b0, ms[i][19:0]}));
        hi_r[i] <= 52'(mc[i]) * 52'($signed(ms[i][SW-1:20]));
      end
    end
  end

  // recombine and round to q21.23
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      full[i] = (72'(hi_r[i]) <<< 20) + 72'(lo_r[i]) + RND_Q28;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= full[i][71:28];
      end
    end
  end

  // new delay values
  assign v1_new = cbq_pkg::sat_sig(46'(prod_r[0]) - 46'(prod_r[1]) + 46'(v2));
  assign v2_new = cbq_pkg::sat_sig(46'(prod_r[2]) - 46'(prod_r[3]));

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= x_in.vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  assign busy = x_in.vld | s0_vld_r | s1_vld_r | s2_vld_r;

endmodule

@@ src/cascaded_biquad_filter_top.sv @@
// Multichannel cascade of transposed direct-form II biquads. While the receiver keeps up,
// a filter word must leave every stage before the next word can be accepted: the gain
// multiply register, its rounding register, then the chain of section cells, and then the
// last cell's delay update (split 32x20 products, then recombination, then the write).
// Each cell owns its section's coefficients and a small memory with every channel's two
// delay values. A coefficient write word gives no result and does not hold up the next
// word. The result passes from the last section's output register through a holding
// register into the output register. A result sitting in the output register does not
// block the next word, but input stalls while a second result waits behind it for the
// receiver.
module cascaded_biquad_filter_top #(
  parameter int SECT_COUNT = 8,
  parameter int CHAN_COUNT = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cbq_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cbq_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic signed [cbq_pkg::COEF_W-1:0] cfg_data
);

  localparam int SW = cbq_pkg::SIG_W;
  localparam logic signed [56:0] X0_RND = 57'sd1 <<< 23;
  localparam logic signed [SW-1:0] OUT_MAX = 40'sd8388607;
  localparam logic signed [SW-1:0] OUT_MIN = -40'sd8388608;

  logic signed [cbq_pkg::COEF_W-1:0] gain_r;
  logic                              accept;
  logic                              is_coef;
  logic                              ch_ok;
  logic                              go;

  logic                              g_vld_r;
  logic signed [55:0]                g_prod_r;
  logic [cbq_pkg::CH_W-1:0]          ch_r;
  logic signed [56:0]                x0_sum;
  logic signed [32:0]                x0_q;
  logic                              x0_vld_r;
  logic signed [SW-1:0]              x0_r;

  cbq_pkg::start_t                   start;
  cbq_pkg::coef_wr_t                 coef_wr;
  cbq_pkg::link_t                    chain [SECT_COUNT+1];
  logic [SECT_COUNT-1:0]             cell_busy;

  logic signed [SW-1:0]              y_last;
  logic signed [cbq_pkg::SMP_W-1:0]  y_sat;
  logic                              pend_r;
  logic signed [cbq_pkg::SMP_W-1:0]  pend_smp_r;
  logic                              move;
  logic                              out_valid_r;
  cbq_pkg::out_item_t                out_r;

  // gain register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= cbq_pkg::GAIN_UNITY;
    end else if (cfg_valid) begin
      gain_r <= cfg_data;
    end
  end

  // input decode
  assign in_ready = !pend_r && !g_vld_r && !x0_vld_r && !(|cell_busy);
  assign accept   = in_valid && in_ready;
  assign is_coef  = (in_data.op == cbq_pkg::OP_COEF);
  assign ch_ok    = int'(in_data.channel) < CHAN_COUNT;
  assign go       = accept && !is_coef && ch_ok;

  assign start.go      = go;
  assign start.channel = in_data.channel;

  assign coef_wr.en      = accept && is_coef;
  assign coef_wr.section = in_data.section;
  assign coef_wr.sel     = in_data.coef_sel;
  assign coef_wr.value   = in_data.coef_value;

  // gain multiply and rounding
  always_ff @(posedge clk) begin
    if (go) begin
      g_prod_r <= 56'(in_data.sample) * 56'(gain_r);
      ch_r     <= in_data.channel;
    end
  end

  assign x0_sum = 57'(g_prod_r) + X0_RND;
  assign x0_q   = x0_sum[56:24];

  always_ff @(posedge clk) begin
    if (g_vld_r) begin
      x0_r <= 40'(x0_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r  <= 1'b0;
      x0_vld_r <= 1'b0;
    end else begin
      g_vld_r  <= go;
      x0_vld_r <= g_vld_r;
    end
  end

  assign chain[0].vld = x0_vld_r;
  assign chain[0].smp = x0_r;

  // chain of section cells
  for (genvar k = 0; k < SECT_COUNT; k++) begin : g_cell
    cbq_cell #(
      .CHAN_COUNT (CHAN_COUNT),
      .CELL_IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (start),
      .coef_wr (coef_wr),
      .x_in    (chain[k]),
      .y_out   (chain[k+1]),
      .busy    (cell_busy[k])
    );
  end

  // output saturation to q1.23
  assign y_last = chain[SECT_COUNT].smp;

  always_comb begin
    if (y_last > OUT_MAX) begin
      y_sat = OUT_MAX[cbq_pkg::SMP_W-1:0];
    end else if (y_last < OUT_MIN) begin
      y_sat = OUT_MIN[cbq_pkg::SMP_W-1:0];
    end else begin
      y_sat = y_last[cbq_pkg::SMP_W-1:0];
    end
  end

  // result holding stage ahead of the output register
  assign move = pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (chain[SECT_COUNT].vld) begin
      pend_smp_r <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (chain[SECT_COUNT].vld) begin
      pend_r <= 1'b1;
    end else if (move) begin
      pend_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_r.channel_out <= ch_r;
      out_r.sample_out  <= pend_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECT_COUNT    = 8;
  localparam int CHAN_COUNT    = 4;
  localparam int CLK_PERIOD    = 4;
  localparam int DIR_ROWS      = 23;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_WORDS   = 160;
  localparam int SETTLE_CYCLES = SECT_COUNT + 8;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  cbq_pkg::in_item_t                 in_data   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  cbq_pkg::out_item_t                out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic signed [cbq_pkg::COEF_W-1:0] cfg_data  = '0;

  // mirror of the block state
  logic signed [cbq_pkg::COEF_W-1:0] gain_mirror;
  logic signed [cbq_pkg::COEF_W-1:0] coef_mirror   [4*SECT_COUNT];
  logic signed [cbq_pkg::SIG_W-1:0]  delay1_mirror [CHAN_COUNT*SECT_COUNT];
  logic signed [cbq_pkg::SIG_W-1:0]  delay2_mirror [CHAN_COUNT*SECT_COUNT];

  cbq_pkg::out_item_t pending_samples [$];
  int                 errors       = 0;
  int                 results_seen = 0;
  int                 hold_left    = 0;
  bit                 quiet        = 1'b0;
  cbq_pkg::out_item_t oldest;

  typedef struct {
    cbq_pkg::in_item_t                word;
    bit                               typed;
    logic signed [cbq_pkg::SMP_W-1:0] want;
  } stim_row_t;

  stim_row_t dir_rows [DIR_ROWS];

  cascaded_biquad_filter_top #(
    .SECT_COUNT (SECT_COUNT),
    .CHAN_COUNT (CHAN_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // clamp a wide sum to the 40-bit q17.23 range
  function automatic logic signed [cbq_pkg::SIG_W-1:0] clamp_sig(
      input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = (48'sd1 <<< (cbq_pkg::SIG_W - 1)) - 48'sd1;
    lo = -(48'sd1 <<< (cbq_pkg::SIG_W - 1));
    if (v > hi) begin
      return hi[cbq_pkg::SIG_W-1:0];
    end else if (v < lo) begin
      return lo[cbq_pkg::SIG_W-1:0];
    end
    return v[cbq_pkg::SIG_W-1:0];
  endfunction

  // exact coefficient product, rounded half up at the q4.28 point
  function automatic logic signed [47:0] coef_mul(
      input logic signed [cbq_pkg::COEF_W-1:0] c,
      input logic signed [cbq_pkg::SIG_W-1:0]  s);
    logic signed [71:0] p;
    p = 72'(c) * 72'(s);
    p = (p + (72'sd1 <<< 27)) >>> 28;
    return p[47:0];
  endfunction

  // one word through the cascade: updates the mirror, gives the filtered sample
  function automatic void cascade_step(input cbq_pkg::in_item_t w, output bit produced,
                                       output cbq_pkg::out_item_t res);
    logic signed [55:0] scaled;
    logic signed [47:0] acc;
    logic signed [cbq_pkg::SIG_W-1:0] x;
    logic signed [cbq_pkg::SIG_W-1:0] y;
    int d;
    produced = 1'b0;
    res = '0;
    if (w.op == cbq_pkg::OP_COEF) begin
      // a section beyond the cascade is dropped
      if (w.section < SECT_COUNT) begin
        coef_mirror[4 * w.section + w.coef_sel] = w.coef_value;
      end
      return;
    end
    // a channel beyond the count is dropped
    if (w.channel >= CHAN_COUNT) begin
      return;
    end
    scaled = 56'(w.sample) * 56'(gain_mirror);
    scaled = (scaled + 56'sd8388608) >>> 24;
    acc = scaled[47:0];
    x = clamp_sig(acc);
    for (int s = 0; s < SECT_COUNT; s++) begin
      d = w.channel * SECT_COUNT + s;
      acc = 48'(delay1_mirror[d]) + 48'(x);
      y = clamp_sig(acc);
      acc = coef_mul(coef_mirror[4*s + cbq_pkg::COEF_B1], x)
            - coef_mul(coef_mirror[4*s + cbq_pkg::COEF_A1], y)
            + 48'(delay2_mirror[d]);
      delay1_mirror[d] = clamp_sig(acc);
      acc = coef_mul(coef_mirror[4*s + cbq_pkg::COEF_B2], x)
            - coef_mul(coef_mirror[4*s + cbq_pkg::COEF_A2], y);
      delay2_mirror[d] = clamp_sig(acc);
      x = y;
    end
    produced = 1'b1;
    res.channel_out = w.channel;
    if (x > 40'sd8388607) begin
      res.sample_out = 24'sh7FFFFF;
    end else if (x < -40'sd8388608) begin
      res.sample_out = 24'sh800000;
    end else begin
      res.sample_out = x[cbq_pkg::SMP_W-1:0];
    end
  endfunction

  function automatic cbq_pkg::in_item_t sample_word(
      input logic [cbq_pkg::CH_W-1:0]         ch,
      input logic signed [cbq_pkg::SMP_W-1:0] smp);
    cbq_pkg::in_item_t w;
    w = '0;
    w.op = cbq_pkg::OP_FILTER;
    w.channel = ch;
    w.sample = smp;
    return w;
  endfunction

  function automatic cbq_pkg::in_item_t coef_word(
      input logic [cbq_pkg::SEC_W-1:0]         sec,
      input logic [cbq_pkg::SEL_W-1:0]         sel,
      input logic signed [cbq_pkg::COEF_W-1:0] val);
    cbq_pkg::in_item_t w;
    w = '0;
    w.op = cbq_pkg::OP_COEF;
    w.section = sec;
    w.coef_sel = sel;
    w.coef_value = val;
    return w;
  endfunction

  // offer one word, with an occasional gap first; valid is left high afterwards
  task automatic issue_word(input cbq_pkg::in_item_t w, input bit typed,
                            input logic signed [cbq_pkg::SMP_W-1:0] want);
    bit produced;
    cbq_pkg::out_item_t res;
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cascade_step(w, produced, res);
    if (produced) begin
      if (typed) begin
        res.sample_out = want;
      end
      pending_samples.push_back(res);
    end
  endtask

  // stop offering, let every result come out and the last update finish
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic signed [cbq_pkg::COEF_W-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gain_mirror = g;
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got ch %0d sample %h",
                   $time, out_data.channel_out, out_data.sample_out);
        end else begin
          oldest = pending_samples.pop_front();
          if (out_data.channel_out !== oldest.channel_out) begin
            errors++;
            $display("%0t: channel_out mismatch, expected %0d, got %0d",
                     $time, oldest.channel_out, out_data.channel_out);
          end
          if (out_data.sample_out !== oldest.sample_out) begin
            errors++;
            $display("%0t: sample_out mismatch, expected %h, got %h",
                     $time, oldest.sample_out, out_data.sample_out);
          end
        end
        results_seen++;
        // one long hold-off so the block backs up and stalls its input
        if (results_seen == 400) begin
          hold_left = 300;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 17);
      end
    end
  end

  // stimulus
  initial begin
    cbq_pkg::in_item_t w;
    logic signed [cbq_pkg::COEF_W-1:0] g;

    gain_mirror = cbq_pkg::GAIN_UNITY;
    for (int i = 0; i < 4*SECT_COUNT; i++) begin
      coef_mirror[i] = '0;
    end
    for (int i = 0; i < CHAN_COUNT*SECT_COUNT; i++) begin
      delay1_mirror[i] = '0;
      delay2_mirror[i] = '0;
    end

    // with all coefficients zero and unity gain each section passes the sample through
    dir_rows = '{
      '{sample_word(2'd0, 24'sh000000), 1'b1, 24'sh000000},
      '{sample_word(2'd1, 24'sh7FFFFF), 1'b1, 24'sh7FFFFF},
      '{sample_word(2'd2, 24'sh800000), 1'b1, 24'sh800000},
      '{sample_word(2'd3, 24'sh000001), 1'b1, 24'sh000001},
      '{sample_word(2'd0, 24'shFFFFFF), 1'b1, 24'shFFFFFF},
      '{sample_word(2'd3, 24'sh555555), 1'b1, 24'sh555555},
      '{sample_word(2'd1, 24'shAAAAAA), 1'b1, 24'shAAAAAA},
      '{coef_word(3'd0, cbq_pkg::COEF_A1, 32'sh7FFFFFFF), 1'b0, '0},
      '{coef_word(3'd0, cbq_pkg::COEF_A2, 32'sh80000000), 1'b0, '0},
      '{coef_word(3'd7, cbq_pkg::COEF_B1, 32'sh7FFFFFFF), 1'b0, '0},
      '{coef_word(3'd7, cbq_pkg::COEF_B2, 32'sh80000000), 1'b0, '0},
      '{coef_word(3'd3, cbq_pkg::COEF_B1, 32'sh10000000), 1'b0, '0},
      '{sample_word(2'd0, 24'sh7FFFFF), 1'b0, '0},
      '{sample_word(2'd0, 24'sh800000), 1'b0, '0},
      '{sample_word(2'd0, 24'sh7FFFFF), 1'b0, '0},
      '{sample_word(2'd2, 24'sh000000), 1'b0, '0},
      '{sample_word(2'd1, 24'sh800000), 1'b0, '0},
      '{coef_word(3'd0, cbq_pkg::COEF_A1, 32'sh00000000), 1'b0, '0},
      '{coef_word(3'd0, cbq_pkg::COEF_A2, 32'sh00000000), 1'b0, '0},
      '{coef_word(3'd5, cbq_pkg::COEF_A1, 32'shF0000000), 1'b0, '0},
      '{sample_word(2'd3, 24'sh400000), 1'b0, '0},
      '{sample_word(2'd3, 24'shC00000), 1'b0, '0},
      '{sample_word(2'd0, 24'sh123456), 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases, each with its own gain and a fresh coefficient set
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      case (p)
        0: g = 32'sh7FFFFFFF;
        1: g = 32'sh80000000;
        2: g = '0;
        3: g = cbq_pkg::GAIN_UNITY;
        4: g = $urandom;
        default: g = int'($urandom_range(0, 67108864)) - 33554432;
      endcase
      write_gain(g);
      quiet = (p == 3);
      for (int s = 0; s < SECT_COUNT; s++) begin
        for (int c = 0; c < 4; c++) begin
          w = {$urandom, $urandom};
          w.op = cbq_pkg::OP_COEF;
          w.section = 3'(s);
          w.coef_sel = 2'(c);
          w.coef_value = int'($urandom_range(0, 268435456)) - 134217728;
          issue_word(w, 1'b0, '0);
        end
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w = {$urandom, $urandom};
        if ($urandom_range(99) < 10) begin
          w.op = cbq_pkg::OP_COEF;
          if ($urandom_range(3) != 0) begin
            w.coef_value = int'($urandom_range(0, 268435456)) - 134217728;
          end
        end else begin
          w.op = cbq_pkg::OP_FILTER;
          if ($urandom_range(1) == 0) begin
            w.sample = 24'(int'($urandom_range(0, 2097152)) - 1048576);
          end
        end
        issue_word(w, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    drain_pipeline();
    if (errors == 0) begin
      $display("PASS cascaded_biquad_filter_top");
    end else begin
      $display("FAIL cascaded_biquad_filter_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL cascaded_biquad_filter_top");
    $finish;
  end

endmodule
